@@ hdl/ebi_pkg.sv @@
// ----------------------------------------------------------------------------
// ebi_pkg
// Shared types and constants of the edge-directed 5x5 Bayer interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package ebi_pkg;

    localparam int CFG_W = 12;
    localparam int ROW_W = 13;
    localparam int EXT_W = 15;
    localparam int WIN_N = 5;
    localparam int LINES = 4;

    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 12'd1920;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 12'd1080;

    typedef struct packed {
        logic inner;
        logic green;
        logic last;
    } t_flags;

endpackage

`default_nettype wire

@@ hdl/ebi_filter.sv @@
// ----------------------------------------------------------------------------
// ebi_filter
// Gradient comparison over the 5x5 window and the registered output word.
// ----------------------------------------------------------------------------
`default_nettype none

module ebi_filter
    import ebi_pkg::*;
#(
    parameter int PIXEL_BITS = 12
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire t_flags                          i_flags,
    input  wire logic [WIN_N*WIN_N*PIXEL_BITS-1:0] i_window,
    output logic                                 o_valid,
    output logic [PIXEL_BITS:0]                  o_value,
    output logic                                 o_is_green,
    output logic                                 o_last
);

    localparam int PB = PIXEL_BITS;
    localparam int GW = PIXEL_BITS + 2;

    logic [PB-1:0] w [0:WIN_N-1][0:WIN_N-1];
    logic [GW-1:0] g_main;
    logic [GW-1:0] g_anti;
    logic [GW-1:0] g_ver;
    logic [GW-1:0] g_hor;
    logic [PB:0]   s_green;
    logic [PB:0]   s_rb;

    logic          r_valid;
    logic [PB:0]   r_value;
    logic          r_green;
    logic          r_last;

    function automatic logic [PB-1:0] absdiff(input logic [PB-1:0] a, input logic [PB-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    always_comb begin
        for (int r = 0; r < WIN_N; r++) begin
            for (int k = 0; k < WIN_N; k++) begin
                w[r][k] = i_window[(r*WIN_N+k)*PB +: PB];
            end
        end
        g_main = GW'(absdiff(w[0][0], w[2][2])) + GW'(absdiff(w[4][4], w[2][2]))
               + GW'(absdiff(w[3][3], w[1][1]));
        g_anti = GW'(absdiff(w[0][4], w[2][2])) + GW'(absdiff(w[4][0], w[2][2]))
               + GW'(absdiff(w[3][1], w[1][3]));
        g_ver  = GW'(absdiff(w[4][2], w[0][2])) + GW'(absdiff(w[3][2], w[1][2]));
        g_hor  = GW'(absdiff(w[2][4], w[2][0])) + GW'(absdiff(w[2][3], w[2][1]));
        s_green = (g_main > g_anti) ? ({1'b0, w[3][1]} + {1'b0, w[1][3]})
                                    : ({1'b0, w[3][3]} + {1'b0, w[1][1]});
        s_rb    = (g_hor > g_ver)   ? ({1'b0, w[4][2]} + {1'b0, w[0][2]})
                                    : ({1'b0, w[2][4]} + {1'b0, w[2][0]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid && i_flags.inner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= i_flags.green ? s_green : s_rb;
            r_green <= i_flags.green;
            r_last  <= i_flags.last;
        end
    end

    assign o_valid    = r_valid;
    assign o_value    = r_value;
    assign o_is_green = r_green;
    assign o_last     = r_last;

endmodule

`default_nettype wire

@@ hdl/edge_directed_bayer_interp_5x5.sv @@
// ----------------------------------------------------------------------------
// edge_directed_bayer_interp_5x5
// Edge-directed 5x5 Bayer interpolation over a frame padded by two on each side.
// ----------------------------------------------------------------------------
// The input channel takes one raw sample per word, in raster order, with
// image_width + 4 samples per row and image_height + 4 rows per frame. The
// output channel gives one word per interior pixel: the chosen unhalved pair
// sum, a green flag and a last flag on the final interior pixel of a frame.
// Padding samples give no output word.
// One sample is taken in every cycle without input stall; the line store is
// a single memory read at the incoming column and written back from the
// registered sample stage, so the rate is one word per clock while the output
// does not stall. A sample passes the read stage, the window and the output register.
// The whole pipeline advances together; when the receiver stalls while an
// output word waits, the input stall rises in the same cycle and all stages
// hold. Reset clears the counters, the pipeline valids, the window and sets
// the size registers to 1920 by 1080. The line store needs no clearing: the
// four rows it holds for a window are written before an output uses them.
// The configuration port writes image_width at index 0 and image_height at 1.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_directed_bayer_interp_5x5
    import ebi_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [PIXEL_BITS-1:0] i_pixel,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [PIXEL_BITS:0]        o_out_value,
    output logic                       o_out_is_green,
    output logic                       o_out_last,
    input  wire logic                  i_cfg_we,
    input  wire logic [0:0]            i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    localparam int PB    = PIXEL_BITS;
    localparam int DEPTH = MAX_WIDTH + 4;
    localparam int COL_W = $clog2(DEPTH);
    localparam int LW    = LINES * PIXEL_BITS;
    localparam logic [EXT_W-1:0] MAX_W_EXT = EXT_W'(MAX_WIDTH);

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic [EXT_W-1:0] w_eff;
    logic [EXT_W-1:0] pw;
    logic [EXT_W-1:0] ph;
    logic             wrap_pre;
    logic [EXT_W-1:0] row_pre;
    logic [COL_W-1:0] c_cur;
    logic [ROW_W-1:0] r_cur;
    logic [EXT_W-1:0] c_inc;
    logic [EXT_W-1:0] r_inc;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    t_flags           fl_cur;

    logic             en;
    logic             acc;

    logic [LW-1:0]    r_mem [0:DEPTH-1];
    logic [LW-1:0]    r_rd;

    logic             r_v1;
    logic [PB-1:0]    r_px1;
    logic [COL_W-1:0] r_c1;
    t_flags           r_fl1;

    logic             r_v2;
    t_flags           r_fl2;
    logic [PB-1:0]    r_win [0:WIN_N-1][0:WIN_N-1];
    logic [PB-1:0]    col_in [0:WIN_N-1];
    logic [WIN_N*WIN_N*PB-1:0] win_flat;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;
    assign acc     = i_valid && en;

    always_comb begin
        if (r_width == '0) begin
            w_eff = EXT_W'(1);
        end else if (EXT_W'(r_width) > MAX_W_EXT) begin
            w_eff = MAX_W_EXT;
        end else begin
            w_eff = EXT_W'(r_width);
        end
        pw = w_eff + EXT_W'(4);
        ph = ((r_height == '0) ? EXT_W'(1) : EXT_W'(r_height)) + EXT_W'(4);

        wrap_pre = EXT_W'(r_col) >= pw;
        row_pre  = wrap_pre ? (EXT_W'(r_row) + EXT_W'(1)) : EXT_W'(r_row);
        c_cur    = wrap_pre ? '0 : r_col;
        r_cur    = (row_pre >= ph) ? '0 : row_pre[ROW_W-1:0];

        c_inc = EXT_W'(c_cur) + EXT_W'(1);
        r_inc = EXT_W'(r_cur) + EXT_W'(1);
        if (c_inc >= pw) begin
            n_col = '0;
            n_row = (r_inc >= ph) ? '0 : r_inc[ROW_W-1:0];
        end else begin
            n_col = c_inc[COL_W-1:0];
            n_row = r_cur;
        end

        fl_cur.inner = (r_cur >= ROW_W'(4)) && (c_cur >= COL_W'(4));
        fl_cur.green = (r_cur[0] ^ c_cur[0]) == 1'b0;
        fl_cur.last  = (EXT_W'(r_cur) == ph - EXT_W'(1)) && (EXT_W'(c_cur) == pw - EXT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_IMAGE_WIDTH;
            r_height <= RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else if (en) begin
            r_v1 <= acc;
            r_v2 <= r_v1;
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px1 <= i_pixel;
            r_c1  <= c_cur;
            r_fl1 <= fl_cur;
            r_fl2 <= r_fl1;
        end
    end

    // Line store: four samples per column, oldest in the low word.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd <= r_mem[c_cur];
        end
        if (en && r_v1) begin
            r_mem[r_c1] <= {r_px1, r_rd[LW-1:PB]};
        end
    end

    always_comb begin
        for (int k = 0; k < LINES; k++) begin
            col_in[k] = r_rd[k*PB +: PB];
        end
        col_in[WIN_N-1] = r_px1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < WIN_N; r++) begin
                for (int k = 0; k < WIN_N; k++) begin
                    r_win[r][k] <= '0;
                end
            end
        end else if (en && r_v1) begin
            for (int r = 0; r < WIN_N; r++) begin
                for (int k = 0; k < WIN_N-1; k++) begin
                    r_win[r][k] <= r_win[r][k+1];
                end
                r_win[r][WIN_N-1] <= col_in[r];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < WIN_N; r++) begin
            for (int k = 0; k < WIN_N; k++) begin
                win_flat[(r*WIN_N+k)*PB +: PB] = r_win[r][k];
            end
        end
    end

    ebi_filter #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_v2),
        .i_flags    (r_fl2),
        .i_window   (win_flat),
        .o_valid    (o_valid),
        .o_value    (o_out_value),
        .o_is_green (o_out_is_green),
        .o_last     (o_out_last)
    );

endmodule

`default_nettype wire
